@@ rtl/cvrb_pkg.sv @@
`timescale 1ns / 1ps

package cvrb_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int CORDIC_STEPS    = 16;

  localparam int ANG_W = 16;
  localparam int OUT_W = 16;

  localparam int DEN_ODD  = 45;
  localparam int HALF_ODD = DEN_ODD / 2;
  localparam int BAM_SH   = 3 + ANGLE_FRAC_BITS;
  localparam int FRAC_W   = 32 - BAM_SH;
  localparam int MAG_W    = ANG_W;
  localparam int RECIP_SH = 26;
  localparam int RECIP    = (1 << RECIP_SH) / DEN_ODD + 1;
  localparam int RECIP_W  = 21;
  localparam int PROD_W   = MAG_W + RECIP_W;
  localparam int QM_W     = 10;
  localparam int RM_W     = 6;
  localparam int MBAM_W   = QM_W + FRAC_W;

  localparam int XY_W = 34;
  localparam int R_W  = 33;
  localparam int SC_W = 32;
  localparam int P_W  = 64;
  localparam int RND_W = 66;

  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint ONE_Q30  = 64'd1073741824;

  localparam int S1 = 30 - OUT_FRAC_BITS;
  localparam int S2 = 60 - OUT_FRAC_BITS;

  typedef logic [FRAC_W-1:0] frac_tab_t [DEN_ODD];

  function automatic frac_tab_t gen_frac_tab();
    frac_tab_t t;
    for (int i = 0; i < DEN_ODD; i++) begin
      t[i] = FRAC_W'(((longint'(i) << FRAC_W) + longint'(HALF_ODD)) / DEN_ODD);
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = gen_frac_tab();

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
    30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005,
    30'h00000003, 30'h00000001, 30'h00000001, 30'h00000000
  };

  typedef struct packed {
    logic [1:0]            quad;
    logic                  zero;
    logic signed [R_W-1:0] resid;
  } bam_t;

  typedef struct packed {
    logic signed [SC_W-1:0] c;
    logic signed [SC_W-1:0] s;
  } sincos_t;

endpackage

@@ rtl/cvrb_bam.sv @@
`timescale 1ns / 1ps

module cvrb_bam (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [cvrb_pkg::ANG_W-1:0]     angle,
  output logic                                  out_valid,
  output cvrb_pkg::bam_t                        out_bam
);

  logic [3:0] vld_r;

  logic [cvrb_pkg::MAG_W-1:0]  mag1_r, mag1_nxt;
  logic [cvrb_pkg::PROD_W-1:0] prod1_r, prod1_nxt;
  logic                        neg1_r;

  logic [cvrb_pkg::QM_W-1:0]   qm2_r, qm2_nxt;
  logic [cvrb_pkg::RM_W-1:0]   rm2_r, rm2_nxt;
  logic                        neg2_r;

  logic [31:0]                 bam3_r, bam3_nxt;
  logic [cvrb_pkg::MBAM_W-1:0] mbam;

  cvrb_pkg::bam_t              bam4_r, bam4_nxt;
  logic [31:0]                 rnd_q;
  logic [1:0]                  quad;
  logic [31:0]                 resid;

  always_comb begin
    mag1_nxt  = angle[cvrb_pkg::ANG_W-1] ? cvrb_pkg::MAG_W'(-angle)
                                         : cvrb_pkg::MAG_W'(angle);
    prod1_nxt = cvrb_pkg::PROD_W'(mag1_nxt) *
                cvrb_pkg::PROD_W'(cvrb_pkg::RECIP);

    qm2_nxt = prod1_r[cvrb_pkg::RECIP_SH +: cvrb_pkg::QM_W];
    rm2_nxt = cvrb_pkg::RM_W'(mag1_r - cvrb_pkg::MAG_W'(qm2_nxt) *
                              cvrb_pkg::MAG_W'(cvrb_pkg::DEN_ODD));

    mbam     = {qm2_r, cvrb_pkg::FRAC_TAB[rm2_r]};
    bam3_nxt = neg2_r ? 32'(-mbam) : 32'(mbam);

    rnd_q          = bam3_r + 32'h2000_0000;
    quad           = rnd_q[31:30];
    resid          = bam3_r - {quad, 30'b0};
    bam4_nxt.quad  = quad;
    bam4_nxt.zero  = (resid == 32'd0);
    bam4_nxt.resid = cvrb_pkg::R_W'($signed(resid));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
    if (en) begin
      mag1_r  <= mag1_nxt;
      prod1_r <= prod1_nxt;
      neg1_r  <= angle[cvrb_pkg::ANG_W-1];
      qm2_r   <= qm2_nxt;
      rm2_r   <= rm2_nxt;
      neg2_r  <= neg1_r;
      bam3_r  <= bam3_nxt;
      bam4_r  <= bam4_nxt;
    end
  end

  assign out_valid = vld_r[3];
  assign out_bam   = bam4_r;

endmodule

@@ rtl/cvrb_cordic.sv @@
`timescale 1ns / 1ps

module cvrb_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  cvrb_pkg::bam_t    in_bam,
  output logic              out_valid,
  output cvrb_pkg::sincos_t out_sc
);

  localparam int N = cvrb_pkg::CORDIC_STEPS;

  logic signed [cvrb_pkg::XY_W-1:0] x_r [N];
  logic signed [cvrb_pkg::XY_W-1:0] y_r [N];
  logic signed [cvrb_pkg::R_W-1:0]  r_r [N];
  logic [1:0]                       quad_r [N];
  logic [N-1:0]                     zero_r;
  logic [N-1:0]                     vld_r;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_step
      logic signed [cvrb_pkg::XY_W-1:0] xs, ys, x_nxt, y_nxt;
      logic signed [cvrb_pkg::R_W-1:0]  rs, r_nxt, at;
      logic [1:0]                       qs;
      logic                             zs, vs;

      if (i == 0) begin : g_first
        assign xs = cvrb_pkg::XY_W'(cvrb_pkg::GAIN_Q30);
        assign ys = '0;
        assign rs = in_bam.resid;
        assign qs = in_bam.quad;
        assign zs = in_bam.zero;
        assign vs = in_valid;
      end else begin : g_next
        assign xs = x_r[i-1];
        assign ys = y_r[i-1];
        assign rs = r_r[i-1];
        assign qs = quad_r[i-1];
        assign zs = zero_r[i-1];
        assign vs = vld_r[i-1];
      end

      assign at = cvrb_pkg::R_W'(cvrb_pkg::ATAN_TAB[i]);

      always_comb begin
        if (!rs[cvrb_pkg::R_W-1]) begin
          x_nxt = xs - (ys >>> i);
          y_nxt = ys + (xs >>> i);
          r_nxt = rs - at;
        end else begin
          x_nxt = xs + (ys >>> i);
          y_nxt = ys - (xs >>> i);
          r_nxt = rs + at;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= vs;
        end
        if (en) begin
          x_r[i]    <= x_nxt;
          y_r[i]    <= y_nxt;
          r_r[i]    <= r_nxt;
          quad_r[i] <= qs;
          zero_r[i] <= zs;
        end
      end
    end
  endgenerate

  logic signed [cvrb_pkg::SC_W-1:0] cr, sr;
  cvrb_pkg::sincos_t                sc_r, sc_nxt;
  logic                             ov_r;

  localparam logic signed [cvrb_pkg::XY_W-1:0] ONE_X = cvrb_pkg::XY_W'(cvrb_pkg::ONE_Q30);

  always_comb begin
    if (zero_r[N-1]) begin
      cr = cvrb_pkg::SC_W'(cvrb_pkg::ONE_Q30);
      sr = '0;
    end else begin
      if (x_r[N-1] > ONE_X) begin
        cr = cvrb_pkg::SC_W'(ONE_X);
      end else if (x_r[N-1] < -ONE_X) begin
        cr = cvrb_pkg::SC_W'(-ONE_X);
      end else begin
        cr = cvrb_pkg::SC_W'(x_r[N-1]);
      end
      if (y_r[N-1] > ONE_X) begin
        sr = cvrb_pkg::SC_W'(ONE_X);
      end else if (y_r[N-1] < -ONE_X) begin
        sr = cvrb_pkg::SC_W'(-ONE_X);
      end else begin
        sr = cvrb_pkg::SC_W'(y_r[N-1]);
      end
    end
    case (quad_r[N-1])
      2'd0: begin
        sc_nxt.c = cr;
        sc_nxt.s = sr;
      end
      2'd1: begin
        sc_nxt.c = -sr;
        sc_nxt.s = cr;
      end
      2'd2: begin
        sc_nxt.c = -cr;
        sc_nxt.s = -sr;
      end
      default: begin
        sc_nxt.c = sr;
        sc_nxt.s = -cr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vld_r[N-1];
    end
    if (en) begin
      sc_r <= sc_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_sc    = sc_r;

endmodule

@@ rtl/cvrb_basis.sv @@
`timescale 1ns / 1ps

module cvrb_basis (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  cvrb_pkg::sincos_t                 hd,
  input  cvrb_pkg::sincos_t                 el,
  output logic                              out_valid,
  output logic signed [cvrb_pkg::OUT_W-1:0] u_x,
  output logic signed [cvrb_pkg::OUT_W-1:0] u_y,
  output logic signed [cvrb_pkg::OUT_W-1:0] u_z,
  output logic signed [cvrb_pkg::OUT_W-1:0] v_x,
  output logic signed [cvrb_pkg::OUT_W-1:0] v_y,
  output logic signed [cvrb_pkg::OUT_W-1:0] v_z,
  output logic signed [cvrb_pkg::OUT_W-1:0] n_x,
  output logic signed [cvrb_pkg::OUT_W-1:0] n_y,
  output logic signed [cvrb_pkg::OUT_W-1:0] n_z,
  output logic                              degenerate
);

  localparam int W = cvrb_pkg::RND_W;

  function automatic logic signed [cvrb_pkg::OUT_W-1:0] rnd_sat(
    input logic signed [W-1:0] v, input int s);
    logic [W-1:0] m;
    logic [W-1:0] h;
    logic signed [cvrb_pkg::OUT_W-1:0] res;
    m = v[W-1] ? W'(-v) : W'(v);
    h = (s == 0) ? '0 : (W'(1) << (s - 1));
    m = (m + h) >> s;
    if (!v[W-1]) begin
      res = (m > W'(32767)) ? 16'sh7FFF : m[cvrb_pkg::OUT_W-1:0];
    end else begin
      res = (m > W'(32768)) ? 16'sh8000 : -m[cvrb_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  logic signed [cvrb_pkg::SC_W-1:0] ch_r, sh_r, ce_r, se_r;
  logic signed [cvrb_pkg::P_W-1:0]  cesh_r, cech_r, sesh_r, sech_r;
  logic                             pv_r, ov_r;

  logic signed [W-1:0] ch_w, sh_w, ce_w, se_w, cesh_w, cech_w, sesh_w, sech_w;
  logic                degen, neg;

  logic signed [cvrb_pkg::OUT_W-1:0] ux_r, uz_r, vx_r, vy_r, vz_r, nx_r, ny_r, nz_r;
  logic signed [cvrb_pkg::OUT_W-1:0] ux_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic                              dg_r;

  always_comb begin
    ch_w   = W'(ch_r);
    sh_w   = W'(sh_r);
    ce_w   = W'(ce_r);
    se_w   = W'(se_r);
    cesh_w = W'(cesh_r);
    cech_w = W'(cech_r);
    sesh_w = W'(sesh_r);
    sech_w = W'(sech_r);
    degen  = (se_r == '0);
    neg    = se_r[cvrb_pkg::SC_W-1];
    if (degen) begin
      ux_nxt = '0;
      uz_nxt = '0;
      vx_nxt = '0;
      vy_nxt = '0;
      vz_nxt = '0;
    end else begin
      ux_nxt = rnd_sat(neg ? ch_w : -ch_w, cvrb_pkg::S1);
      uz_nxt = rnd_sat(neg ? sh_w : -sh_w, cvrb_pkg::S1);
      vx_nxt = rnd_sat(neg ? -cesh_w : cesh_w, cvrb_pkg::S2);
      vy_nxt = rnd_sat(neg ? -se_w : se_w, cvrb_pkg::S1);
      vz_nxt = rnd_sat(neg ? cech_w : -cech_w, cvrb_pkg::S2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      pv_r <= in_valid;
      ov_r <= pv_r;
    end
    if (en) begin
      ch_r   <= hd.c;
      sh_r   <= hd.s;
      ce_r   <= el.c;
      se_r   <= el.s;
      cesh_r <= cvrb_pkg::P_W'(el.c) * cvrb_pkg::P_W'(hd.s);
      cech_r <= cvrb_pkg::P_W'(el.c) * cvrb_pkg::P_W'(hd.c);
      sesh_r <= cvrb_pkg::P_W'(el.s) * cvrb_pkg::P_W'(hd.s);
      sech_r <= cvrb_pkg::P_W'(el.s) * cvrb_pkg::P_W'(hd.c);
      ux_r   <= ux_nxt;
      uz_r   <= uz_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      vz_r   <= vz_nxt;
      nx_r   <= rnd_sat(sesh_w, cvrb_pkg::S2);
      ny_r   <= rnd_sat(-ce_w, cvrb_pkg::S1);
      nz_r   <= rnd_sat(-sech_w, cvrb_pkg::S2);
      dg_r   <= degen;
    end
  end

  assign out_valid  = ov_r;
  assign u_x        = ux_r;
  assign u_y        = '0;
  assign u_z        = uz_r;
  assign v_x        = vx_r;
  assign v_y        = vy_r;
  assign v_z        = vz_r;
  assign n_x        = nx_r;
  assign n_y        = ny_r;
  assign n_z        = nz_r;
  assign degenerate = dg_r;

endmodule

@@ rtl/camera_view_rotation_basis_core.sv @@
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless the output stalls; 4 angle
// stages, one CORDIC stage per step (16) plus quadrant fold, then a multiply
// stage and a round stage.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset: synchronous, active low; clears all valid bits, no result pending.
module camera_view_rotation_basis_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cvrb_pkg::ANG_W-1:0] in_heading,
  input  logic signed [cvrb_pkg::ANG_W-1:0] in_elevation,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_u_x,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_u_y,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_u_z,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_v_x,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_v_y,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_v_z,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_n_x,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_n_y,
  output logic signed [cvrb_pkg::OUT_W-1:0] out_n_z,
  output logic                              out_degenerate
);

  logic              en;
  logic              hb_v, eb_v, hc_v, ec_v;
  cvrb_pkg::bam_t    hb, eb;
  cvrb_pkg::sincos_t hc, ec;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cvrb_bam u_bam_h (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .angle(in_heading), .out_valid(hb_v), .out_bam(hb)
  );

  cvrb_bam u_bam_e (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .angle(in_elevation), .out_valid(eb_v), .out_bam(eb)
  );

  cvrb_cordic u_cordic_h (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(hb_v),
    .in_bam(hb), .out_valid(hc_v), .out_sc(hc)
  );

  cvrb_cordic u_cordic_e (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(eb_v),
    .in_bam(eb), .out_valid(ec_v), .out_sc(ec)
  );

  cvrb_basis u_basis (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(hc_v && ec_v),
    .hd(hc), .el(ec), .out_valid(out_valid),
    .u_x(out_u_x), .u_y(out_u_y), .u_z(out_u_z),
    .v_x(out_v_x), .v_y(out_v_y), .v_z(out_v_z),
    .n_x(out_n_x), .n_y(out_n_y), .n_z(out_n_z),
    .degenerate(out_degenerate)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_degen_zero_uv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_u_x == 0 && out_u_z == 0 && out_v_x == 0 && out_v_y == 0 && out_v_z == 0)
    else $error("degenerate basis with nonzero u or v");

  a_degen_zero_nxz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_n_x == 0 && out_n_z == 0)
    else $error("degenerate basis with nonzero n_x or n_z");

endmodule
